>>> src/cssp_pkg.sv
package cssp_pkg;

    // Processor states per sample: user, nice, system, idle (lane 0 .. 3)
    localparam int STATE_COUNT = 4;
    localparam int TICK_W      = 32;
    localparam int SHARE_W     = 10;

    // Quotient bits of the rounding divide (shares never exceed 1000)
    localparam int QUO_BITS = 11;

    // 1000 * d = (d << 10) - (d << 4) - (d << 3)
    localparam int SHIFT_HI  = 10;
    localparam int SHIFT_MID = 4;
    localparam int SHIFT_LO  = 3;

    // Divider sequencer steps per lane: three setup steps, then one quotient bit per step
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_ADD_HI  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_SUB_MID = 4'd1;
    localparam logic [STEP_W-1:0] STEP_SUB_LO  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_LAST    = 4'd13;

    typedef struct packed {
        logic [TICK_W-1:0] user_ticks;
        logic [TICK_W-1:0] nice_ticks;
        logic [TICK_W-1:0] system_ticks;
        logic [TICK_W-1:0] idle_ticks;
    } sample_t;

    typedef struct packed {
        logic [SHARE_W-1:0] user_permille;
        logic [SHARE_W-1:0] nice_permille;
        logic [SHARE_W-1:0] system_permille;
        logic [SHARE_W-1:0] idle_permille;
    } share_t;

    typedef struct packed {
        logic load;
        logic shift;
    } delta_ctl_t;

endpackage

>>> src/cpu_state_share_permille.sv
// The bit-serial delta pass runs over all COUNTER_WIDTH bits, then the shared divider works
// through the states in turn (3 setup steps, 11 quotient bits each) before the hand-off.
// A new sample is taken only after the previous one has been handed off.
// A finished share waits in its output register.
// Reset (rst_n, async, active low) clears the previous counts to zero and empties the output.
module cpu_state_share_permille #(
    parameter int COUNTER_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  cssp_pkg::sample_t sample,
    output logic              share_valid,
    input  logic              share_stall,
    output cssp_pkg::share_t  share
);
    import cssp_pkg::*;

    localparam int CW   = COUNTER_WIDTH;
    localparam int TW   = CW + $clog2(STATE_COUNT);
    localparam int CNTW = $clog2(CW);
    localparam logic [CNTW-1:0] CNT_LAST = CNTW'(CW - 1);

    // Control sequence: idle -> serial delta pass -> divider start -> divide -> hand off
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SHIFT  = 5'b00010,
        ST_START  = 5'b00100,
        ST_DIVIDE = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t                              state_reg;
    state_t                              state_next;
    logic [CNTW-1:0]                     cnt_reg;
    logic                                share_valid_reg;
    share_t                              share_reg;
    logic                                in_xfer;
    logic                                out_load;
    delta_ctl_t                          dctl;
    logic [STATE_COUNT-1:0][CW-1:0]      now_vec;
    logic [STATE_COUNT-1:0][CW-1:0]      delta_vec;
    logic [TW-1:0]                       total;
    logic                                div_busy;
    logic [STATE_COUNT-1:0][SHARE_W-1:0] div_share;

    // Take a new sample only when nothing is in flight
    assign sample_stall = (state_reg != ST_IDLE);
    assign in_xfer      = sample_valid && !sample_stall;

    // Hand off once the output register is empty or being drained this cycle
    assign out_load = (state_reg == ST_DONE) && (!share_valid_reg || !share_stall);

    // Counters narrower or wider than the field width: drop or zero-fill upper bits
    always_comb
    begin
        now_vec[0] = CW'(sample.user_ticks);
        now_vec[1] = CW'(sample.nice_ticks);
        now_vec[2] = CW'(sample.system_ticks);
        now_vec[3] = CW'(sample.idle_ticks);
    end

    always_comb
    begin
        dctl.load  = in_xfer;
        dctl.shift = (state_reg == ST_SHIFT);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_xfer)
                    state_next = ST_SHIFT;
            ST_SHIFT:
                if (cnt_reg == CNT_LAST)
                    state_next = ST_START;
            ST_START:
                state_next = ST_DIVIDE;
            ST_DIVIDE:
                if (!div_busy)
                    state_next = ST_DONE;
            ST_DONE:
                if (out_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            share_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // Advance the bit counter only during the serial pass
            if (state_reg == ST_SHIFT)
                cnt_reg <= cnt_reg + 1'b1;
            else
                cnt_reg <= '0;
            if (out_load)
                share_valid_reg <= 1'b1;
            else if (!share_stall)
                share_valid_reg <= 1'b0;
        end
    end

    // Output register; holds while the consumer stalls
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            share_reg.user_permille   <= div_share[0];
            share_reg.nice_permille   <= div_share[1];
            share_reg.system_permille <= div_share[2];
            share_reg.idle_permille   <= div_share[3];
        end
    end

    assign share_valid = share_valid_reg;
    assign share       = share_reg;

    cssp_delta #(
        .CW(CW)
    ) u_delta (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (dctl),
        .now   (now_vec),
        .delta (delta_vec),
        .total (total)
    );

    cssp_div #(
        .CW(CW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_START),
        .delta (delta_vec),
        .total (total),
        .busy  (div_busy),
        .share (div_share)
    );

    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !div_busy)
        else $error("divider busy while idle");

    a_xfer_starts_pass: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg == ST_SHIFT && cnt_reg == '0)
        else $error("sample transfer did not start the delta pass");

    a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_START |=> div_busy)
        else $error("divider did not start");

    a_share_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(share_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("share presented without a finished divide");

endmodule

>>> src/cssp_delta.sv
module cssp_delta #(
    parameter int CW = 32
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  cssp_pkg::delta_ctl_t                          ctl,
    input  logic [cssp_pkg::STATE_COUNT-1:0][CW-1:0]      now,
    output logic [cssp_pkg::STATE_COUNT-1:0][CW-1:0]      delta,
    output logic [CW+$clog2(cssp_pkg::STATE_COUNT)-1:0]   total
);
    import cssp_pkg::*;

    localparam int CBW  = $clog2(STATE_COUNT);
    localparam int SUMW = $clog2(2 * STATE_COUNT);
    localparam int TW   = CW + CBW;

    logic [STATE_COUNT-1:0][CW-1:0] now_reg;
    logic [STATE_COUNT-1:0][CW-1:0] prev_reg;
    logic [STATE_COUNT-1:0][CW-1:0] delta_reg;
    logic [STATE_COUNT-1:0]         borrow_reg;
    logic [STATE_COUNT-1:0]         borrow_next;
    logic [STATE_COUNT-1:0]         n_bit;
    logic [STATE_COUNT-1:0]         p_bit;
    logic [STATE_COUNT-1:0]         d_bit;
    logic [CBW-1:0]                 carry_reg;
    logic [SUMW-1:0]                col_sum;
    logic [CW-1:0]                  tot_reg;
    logic [TW-1:0]                  tot_raw;

    // Serial subtract per lane, LSB first; column sum of all lanes feeds the total
    always_comb
    begin
        col_sum = SUMW'(carry_reg);
        for (int i = 0; i < STATE_COUNT; i++)
        begin
            n_bit[i]       = now_reg[i][0];
            p_bit[i]       = prev_reg[i][0];
            d_bit[i]       = n_bit[i] ^ p_bit[i] ^ borrow_reg[i];
            borrow_next[i] = (~n_bit[i] & p_bit[i]) | (~(n_bit[i] ^ p_bit[i]) & borrow_reg[i]);
            col_sum        = col_sum + SUMW'(d_bit[i]);
        end
    end

    // All-zero progress is taken as a total of one
    assign tot_raw = {carry_reg, tot_reg};
    assign total   = (tot_raw == '0) ? TW'(1) : tot_raw;
    assign delta   = delta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= '0;
            borrow_reg <= '0;
            carry_reg  <= '0;
        end
        else if (ctl.load)
        begin
            borrow_reg <= '0;
            carry_reg  <= '0;
        end
        else if (ctl.shift)
        begin
            borrow_reg <= borrow_next;
            carry_reg  <= CBW'(col_sum >> 1);
            // Retire the old sample as the new one streams past
            for (int i = 0; i < STATE_COUNT; i++)
                prev_reg[i] <= {now_reg[i][0], prev_reg[i][CW-1:1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
            now_reg <= now;
        else if (ctl.shift)
        begin
            tot_reg <= {col_sum[0], tot_reg[CW-1:1]};
            for (int i = 0; i < STATE_COUNT; i++)
            begin
                now_reg[i]   <= now_reg[i] >> 1;
                delta_reg[i] <= {d_bit[i], delta_reg[i][CW-1:1]};
            end
        end
    end

endmodule

>>> src/cssp_div.sv
module cssp_div #(
    parameter int CW = 32
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                start,
    input  logic [cssp_pkg::STATE_COUNT-1:0][CW-1:0]            delta,
    input  logic [CW+$clog2(cssp_pkg::STATE_COUNT)-1:0]         total,
    output logic                                                busy,
    output logic [cssp_pkg::STATE_COUNT-1:0][cssp_pkg::SHARE_W-1:0] share
);
    import cssp_pkg::*;

    localparam int TW = CW + $clog2(STATE_COUNT);
    localparam int NW = TW + QUO_BITS - 1;
    localparam int LW = $clog2(STATE_COUNT);
    localparam logic [LW-1:0] LANE_LAST = LW'(STATE_COUNT - 1);

    logic                                busy_reg;
    logic [LW-1:0]                       lane_reg;
    logic [STEP_W-1:0]                   step_reg;
    logic [TW-1:0]                       tot_reg;
    logic [NW-1:0]                       rem_reg;
    logic [NW-1:0]                       rem_next;
    logic [NW-1:0]                       dsh_reg;
    logic [NW-1:0]                       dsh_next;
    logic [QUO_BITS-1:0]                 q_reg;
    logic [QUO_BITS-1:0]                 q_next;
    logic [STATE_COUNT-1:0][SHARE_W-1:0] share_reg;
    logic [CW-1:0]                       d_sel;
    logic [NW-1:0]                       dx;
    logic [NW-1:0]                       half;
    logic [NW-1:0]                       diff;
    logic                                ge;

    always_comb
    begin
        d_sel  = delta[lane_reg];
        dx     = NW'(d_sel);
        half   = NW'(tot_reg >> 1);
        ge     = (rem_reg >= dsh_reg);
        diff   = rem_reg - dsh_reg;
        q_next = {q_reg[QUO_BITS-2:0], ge};
        rem_next = rem_reg;
        dsh_next = dsh_reg;
        case (step_reg)
            STEP_ADD_HI:
                rem_next = half + (dx << SHIFT_HI);
            STEP_SUB_MID:
                rem_next = rem_reg - (dx << SHIFT_MID);
            STEP_SUB_LO:
            begin
                rem_next = rem_reg - (dx << SHIFT_LO);
                dsh_next = NW'(tot_reg) << (QUO_BITS - 1);
            end
            default:
            begin
                rem_next = ge ? diff : rem_reg;
                dsh_next = dsh_reg >> 1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            lane_reg <= '0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            lane_reg <= '0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg == STEP_LAST)
            begin
                step_reg <= '0;
                if (lane_reg == LANE_LAST)
                    busy_reg <= 1'b0;
                else
                    lane_reg <= lane_reg + 1'b1;
            end
            else
                step_reg <= step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            tot_reg <= total;
        if (busy_reg)
        begin
            rem_reg <= rem_next;
            dsh_reg <= dsh_next;
            if (step_reg == STEP_SUB_LO)
                q_reg <= '0;
            else if (step_reg > STEP_SUB_LO)
                q_reg <= q_next;
            // Shift finished lanes down so lane 0 lands at index 0
            if (step_reg == STEP_LAST)
            begin
                share_reg[STATE_COUNT-1] <= q_next[SHARE_W-1:0];
                for (int i = 0; i < STATE_COUNT - 1; i++)
                    share_reg[i] <= share_reg[i+1];
            end
        end
    end

    assign busy  = busy_reg;
    assign share = share_reg;

endmodule
